// ===== rtl/core/fsic_pkg.sv =====
// Shared constants and types for the first-seen id compactor.
`timescale 1ns / 1ps
`default_nettype none
package fsic_pkg;

  localparam int TABLE_SIZE = 1024;
  localparam int ID_BITS    = 32;
  localparam int NODE_W     = 32;
  localparam int DENSE_W    = 10;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef logic [ID_BITS-1:0] key_t;

  typedef struct packed {
    key_t key;
    logic batch_start;
  } fsic_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } fsic_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/fsic_if.sv =====
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps
`default_nettype none
interface fsic_in_if;
  logic                      valid;
  logic                      ready;
  logic [fsic_pkg::NODE_W-1:0] node_id;
  logic                      batch_start;

  modport source (output valid, output node_id, output batch_start, input ready);
  modport sink   (input valid, input node_id, input batch_start, output ready);
endinterface

interface fsic_out_if;
  logic                        valid;
  logic                        ready;
  logic [fsic_pkg::DENSE_W-1:0] dense_id;
  logic                        is_new;
  logic                        table_full;

  modport source (output valid, output dense_id, output is_new, output table_full,
                  input ready);
  modport sink   (input valid, input dense_id, input is_new, input table_full,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fsic_front.sv =====
// Front end: accepts words, forms the lookup key and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module fsic_front (
  input  logic                 clk,
  input  logic                 rst_n,
  fsic_in_if.sink              in_ch,
  output logic                 q_vld,
  input  logic                 q_rdy,
  output fsic_pkg::fsic_item_t q_item
);
  import fsic_pkg::*;

  fsic_item_t          q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push, pop;
  fsic_item_t          new_item;

  // only the low ID_BITS of the node id take part in the lookup
  always_comb begin
    new_item.key         = key_t'(in_ch.node_id);
    new_item.batch_start = in_ch.batch_start;
  end

  assign in_ch.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign q_vld       = (cnt_r != '0);
  assign q_item      = q_mem_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_vld && q_rdy;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fsic_back.sv =====
// Back end: scans the id table one entry per cycle, then hits, inserts or reports full.
`timescale 1ns / 1ps
`default_nettype none
module fsic_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_vld,
  output logic                        q_rdy,
  input  fsic_pkg::fsic_item_t        q_item,
  fsic_out_if.source                  out_ch,
  output logic [fsic_pkg::CNT_W-1:0]  used
);
  import fsic_pkg::*;

  key_t                id_mem [TABLE_SIZE];

  fsic_state_t         state_r, state_nxt;
  key_t                key_r, key_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  key_t                rd_data_r;

  logic                out_vld_r;
  logic [DENSE_W-1:0]  out_dense_r;
  logic                out_new_r;
  logic                out_full_r;

  logic                out_free;
  logic                hit;
  logic                rd_en, wr_en, load_out;
  logic [DENSE_W-1:0]  res_dense;
  logic                res_new, res_full;

  assign out_free = !out_vld_r || out_ch.ready;
  // read data is registered: it arrives in the cycle after its address is issued
  assign hit      = cmp_vld_r && (rd_data_r == key_r);

  always_comb begin
    state_nxt   = state_r;
    key_nxt     = key_r;
    used_nxt    = used_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    q_rdy       = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    load_out    = 1'b0;
    res_dense   = '0;
    res_new     = 1'b0;
    res_full    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_rdy = out_free;
        if (q_vld && out_free) begin
          key_nxt    = q_item.key;
          rd_idx_nxt = '0;
          if (q_item.batch_start) begin
            used_nxt = '0;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          load_out  = 1'b1;
          res_dense = DENSE_W'(cmp_idx_r);
          state_nxt = ST_IDLE;
        end else if (rd_idx_r < used_r) begin
          rd_en       = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end else if (used_r == CNT_W'(TABLE_SIZE)) begin
          load_out  = 1'b1;
          res_full  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          // every valid entry missed: take the next free slot
          wr_en     = 1'b1;
          load_out  = 1'b1;
          res_new   = 1'b1;
          res_dense = DENSE_W'(used_r);
          used_nxt  = used_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      used_r    <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    if (load_out) begin
      out_dense_r <= res_dense;
      out_new_r   <= res_new;
      out_full_r  <= res_full;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[used_r[IDX_W-1:0]] <= key_r;
    end
    if (rd_en) begin
      rd_data_r <= id_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.dense_id   = out_dense_r;
  assign out_ch.is_new     = out_new_r;
  assign out_ch.table_full = out_full_r;
  assign used              = used_r;

endmodule
`default_nettype wire

// ===== rtl/core/first_seen_id_compactor_top.sv =====
// Top level of the first-seen id compactor: front queue plus table scan engine.
//
// Usage:
//   in_ch  : one word per node id (node_id, batch_start), valid/ready.
//   out_ch : one word per input word (dense_id, is_new, table_full), valid/ready.
//   Dense ids are handed out 0, 1, 2, ... in order of first appearance within a
//   batch. batch_start empties the table before its word is looked up.
//   A two-entry queue sits between the input and the scan engine, so input words
//   are taken while a lookup runs or a result waits in the output register.
//   Lookup: the engine reads one table entry per cycle from a single-port id
//   memory. A hit ends the scan when the matching entry is compared; a miss
//   scans every entry in use, then inserts the key or reports full. The word
//   first passes through the queue, and after each result the engine goes back
//   to idle before it takes the next word, so it works on one word at a time.
//   Reset clears the queue, the entry count and the output register; the id
//   memory is not cleared, since only slots below the entry count are read.
//   A stalled receiver holds the result; the engine starts no new lookup until
//   the output register is free, and the queue then fills and drops in_ch.ready.
`timescale 1ns / 1ps
`default_nettype none
module first_seen_id_compactor_top (
  input  logic        clk,
  input  logic        rst_n,
  fsic_in_if.sink     in_ch,
  fsic_out_if.source  out_ch
);
  import fsic_pkg::*;

  logic              q_vld;
  logic              q_rdy;
  fsic_item_t        q_item;
  logic [CNT_W-1:0]  used;

  fsic_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_vld  (q_vld),
    .q_rdy  (q_rdy),
    .q_item (q_item)
  );

  fsic_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_vld  (q_vld),
    .q_rdy  (q_rdy),
    .q_item (q_item),
    .out_ch (out_ch),
    .used   (used)
  );

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.is_new && out_ch.table_full))
    else $error("is_new and table_full both set");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.table_full |-> used == CNT_W'(TABLE_SIZE))
    else $error("table_full reported with free slots");

  a_new_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_new |-> out_ch.dense_id == DENSE_W'(used - CNT_W'(1)))
    else $error("new dense id does not match last filled slot");

endmodule
`default_nettype wire

// ===== sim/fsic_scoreboard.sv =====
// Scoreboard for the id compactor: predicts each result word and checks it.
`timescale 1ns / 1ps
module fsic_scoreboard (
  input  logic clk,
  input  logic rst_n,
  fsic_in_if   in_mon,
  fsic_out_if  out_mon,
  output int   err_count,
  output int   words_pending,
  output int   new_count,
  output int   hit_count,
  output int   full_count,
  output int   batch_count
);
  import fsic_pkg::*;

  typedef struct packed {
    logic [DENSE_W-1:0] dense_id;
    logic               is_new;
    logic               table_full;
  } dense_result_t;

  key_t          slot_keys [TABLE_SIZE];
  int            slots_used;
  dense_result_t dense_ids_due[$];

  // Looks the key up among the live slots, inserts it on a miss if room is left.
  function automatic dense_result_t relabel(input logic [NODE_W-1:0] node,
                                            input logic start);
    key_t          key;
    dense_result_t res;
    key = key_t'(node);
    res = '0;
    if (start) slots_used = 0;
    for (int i = 0; i < slots_used; i++) begin
      if (slot_keys[i] == key) begin
        res.dense_id = DENSE_W'(i);
        return res;
      end
    end
    if (slots_used < TABLE_SIZE) begin
      slot_keys[slots_used] = key;
      res.dense_id = DENSE_W'(slots_used);
      res.is_new = 1'b1;
      slots_used++;
    end else begin
      res.table_full = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    dense_result_t want;
    dense_result_t got;
    if (!rst_n) begin
      slots_used = 0;
      dense_ids_due.delete();
      words_pending = 0;
    end else begin
      // enqueue before dequeue: a word's result never leaves on the edge that takes it
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.batch_start) batch_count++;
        dense_ids_due.insert(dense_ids_due.size(),
                             relabel(in_mon.node_id, in_mon.batch_start));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.dense_id   = out_mon.dense_id;
        got.is_new     = out_mon.is_new;
        got.table_full = out_mon.table_full;
        if (dense_ids_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result word: dense_id=%0d is_new=%b table_full=%b",
                   $time, got.dense_id, got.is_new, got.table_full);
        end else begin
          want = dense_ids_due.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: mismatch: expected dense_id=%0d is_new=%b table_full=%b, ",
                     $time, want.dense_id, want.is_new, want.table_full,
                     "got dense_id=%0d is_new=%b table_full=%b",
                     got.dense_id, got.is_new, got.table_full);
          end
          if (want.table_full) full_count++;
          else if (want.is_new) new_count++;
          else hit_count++;
        end
      end
      words_pending = dense_ids_due.size();
    end
  end

endmodule

// ===== sim/first_seen_id_compactor_top_test.sv =====
// Testbench top for the id compactor: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module first_seen_id_compactor_top_test;
  import fsic_pkg::*;

  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int          RANDOM_WORDS = 800;
  localparam logic [31:0] FILL_MULT = 32'h9E37_79B1;  // odd, so i -> id is one-to-one
  localparam logic [31:0] FILL_BASE = 32'h1234_5678;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   tx_max_gap = 19;
  int   rx_max_stall = 19;
  int   cycle_count = 0;
  int   total_words = 0;

  int errors, pending, n_new, n_hit, n_full, n_batch;

  fsic_in_if  in_ch();
  fsic_out_if out_ch();

  first_seen_id_compactor_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fsic_scoreboard scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .err_count     (errors),
    .words_pending (pending),
    .new_count     (n_new),
    .hit_count     (n_hit),
    .full_count    (n_full),
    .batch_count   (n_batch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // handshake flags, read at the following falling edge
  always @(posedge clk) begin
    in_took  <= in_ch.valid && in_ch.ready;
    out_took <= out_ch.valid && out_ch.ready;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("first_seen_id_compactor_top_test failed");
      $finish;
    end
  end

  function automatic logic [NODE_W-1:0] fill_id(input int idx);
    return 32'(idx) * FILL_MULT + FILL_BASE;
  endfunction

  task automatic send_word(input logic [NODE_W-1:0] node, input logic start);
    int gap;
    gap = $urandom_range(tx_max_gap, 0);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.node_id     = node;
    in_ch.batch_start = start;
    do @(negedge clk); while (!in_took);
    total_words++;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // result side: random stall before each word
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = $urandom_range(rx_max_stall, 0);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(negedge clk); while (!out_took);
    end
  end

  initial begin
    logic [NODE_W-1:0] pool [16];
    logic [NODE_W-1:0] node;
    logic              start;
    int                batch_len;
    int                since_start;
    int                sent;
    in_ch.valid       = 1'b0;
    in_ch.node_id     = '0;
    in_ch.batch_start = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // first words after reset need no batch start; extremes and repeats
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hA5A5_A5A5, 1'b0);
    send_word(32'h5A5A_5A5A, 1'b0);
    drain();
    // batch start on an id already in the table, then back-to-back starts
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0007, 1'b1);
    send_word(32'h0000_0007, 1'b1);
    send_word(32'h0000_0007, 1'b0);
    drain();

    // fill every slot, then misses on a full table and hits at both ends
    for (int i = 0; i < TABLE_SIZE; i++) send_word(fill_id(i), i == 0);
    drain();
    send_word(fill_id(TABLE_SIZE), 1'b0);
    send_word(fill_id(TABLE_SIZE + 1), 1'b0);
    send_word(fill_id(TABLE_SIZE - 1), 1'b0);
    send_word(fill_id(0), 1'b0);
    send_word(fill_id(TABLE_SIZE / 2), 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(fill_id(5), 1'b1);
    send_word(fill_id(TABLE_SIZE - 1), 1'b0);
    drain();

    // random batches drawn mostly from a small pool so repeats are common
    sent = 0;
    since_start = 0;
    while (sent < RANDOM_WORDS) begin
      foreach (pool[k]) pool[k] = $urandom();
      batch_len = $urandom_range(48, 1);
      start = (since_start > 200) || ($urandom_range(7, 0) != 0);
      if ($urandom_range(3, 0) == 0) begin
        tx_max_gap   = 0;
        rx_max_stall = 0;
      end else begin
        tx_max_gap   = 19;
        rx_max_stall = 19;
      end
      for (int k = 0; k < batch_len; k++) begin
        case ($urandom_range(9, 0))
          0, 1: node = $urandom();
          2: begin
            node = 32'h1 << $urandom_range(31, 0);
            if ($urandom_range(1, 0) == 1) node = ~node;
          end
          default: node = pool[$urandom_range(15, 0)];
        endcase
        if (k > 0) start = ($urandom_range(63, 0) == 0);
        if (start) since_start = 0;
        send_word(node, start);
        since_start++;
        sent++;
      end
      if ($urandom_range(9, 0) == 0) drain();
    end
    drain();
    repeat (64) @(negedge clk);

    $display("Ran %0d words in %0d batches over %0d cycles, including a full table.",
             total_words, n_batch, cycle_count);
    $display("Results: %0d new ids, %0d repeats, %0d table-full words.",
             n_new, n_hit, n_full);
    if (errors == 0) begin
      $display("first_seen_id_compactor_top_test passed");
    end else begin
      $display("first_seen_id_compactor_top_test failed");
    end
    $finish;
  end

endmodule
